### rtl/pdsteer_pkg.sv
// pdsteer_pkg: shared types and constants of the steering pd controller
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pdsteer_pkg;

  localparam int GAIN_W      = 8;
  localparam int THR_W       = 11;
  localparam int DRIVE_W     = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [THR_W-1:0] LARGE_THR_RESET = THR_W'(70);
  localparam logic [THR_W-1:0] DEADBAND_RESET  = THR_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LARGE_KP  = 3'd0,
    REG_LARGE_KD  = 3'd1,
    REG_INIT_KP   = 3'd2,
    REG_INIT_KD   = 3'd3,
    REG_LARGE_THR = 3'd4,
    REG_DEADBAND  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] kd;
  } gains_t;

endpackage

`default_nettype wire

### rtl/pdsteer_front.sv
// pdsteer_front: configuration registers, gain selection, deadband test,
// error history and derivative term; uses pdsteer_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdsteer_front #(
  parameter int ERROR_WIDTH = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [pdsteer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pdsteer_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                accept,
  input  wire logic signed [ERROR_WIDTH-1:0]       error_sample,
  output logic signed [ERROR_WIDTH-1:0]            op_error,
  output logic signed [ERROR_WIDTH+2:0]            op_deriv,
  output pdsteer_pkg::gains_t                      op_gains,
  output logic                                     op_active
);

  localparam int EW = ERROR_WIDTH;
  localparam int DW = EW + 3;
  localparam int CW = (EW > pdsteer_pkg::THR_W) ? EW : pdsteer_pkg::THR_W;

  pdsteer_pkg::gains_t              large_gains;
  pdsteer_pkg::gains_t              active_gains;
  logic [pdsteer_pkg::THR_W-1:0]    large_threshold;
  logic [pdsteer_pkg::THR_W-1:0]    deadband;
  logic signed [EW-1:0]             prev_error_1;
  logic signed [EW-1:0]             prev_error_2;
  logic signed [EW-1:0]             prev_error_3;

  logic [EW-1:0]       mag;
  logic                is_large;
  logic                is_outside;
  logic signed [DW-1:0] e0x;
  logic signed [DW-1:0] e1x;
  logic signed [DW-1:0] e3x;

  always_comb begin
    mag        = error_sample[EW-1] ? EW'(-error_sample) : EW'(error_sample);
    is_large   = CW'(mag) > CW'(large_threshold);
    is_outside = CW'(mag) > CW'(deadband);
    e0x        = DW'(error_sample);
    e1x        = DW'(prev_error_1);
    e3x        = DW'(prev_error_3);
  end

  // 3*(e0-e1) + (e1-e2) + (e2-e3) collapses to 3*e0 - 2*e1 - e3
  assign op_deriv  = (e0x <<< 1) + e0x - (e1x <<< 1) - e3x;
  assign op_error  = error_sample;
  assign op_gains  = is_large ? large_gains : active_gains;
  assign op_active = is_outside;

  always_ff @(posedge clk) begin
    if (rst) begin
      large_gains     <= '0;
      active_gains    <= '0;
      large_threshold <= pdsteer_pkg::LARGE_THR_RESET;
      deadband        <= pdsteer_pkg::DEADBAND_RESET;
      prev_error_1    <= '0;
      prev_error_2    <= '0;
      prev_error_3    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          pdsteer_pkg::REG_LARGE_KP:  large_gains.kp  <= cfg_data[pdsteer_pkg::GAIN_W-1:0];
          pdsteer_pkg::REG_LARGE_KD:  large_gains.kd  <= cfg_data[pdsteer_pkg::GAIN_W-1:0];
          pdsteer_pkg::REG_INIT_KP:   active_gains.kp <= cfg_data[pdsteer_pkg::GAIN_W-1:0];
          pdsteer_pkg::REG_INIT_KD:   active_gains.kd <= cfg_data[pdsteer_pkg::GAIN_W-1:0];
          pdsteer_pkg::REG_LARGE_THR: large_threshold <= cfg_data[pdsteer_pkg::THR_W-1:0];
          pdsteer_pkg::REG_DEADBAND:  deadband        <= cfg_data[pdsteer_pkg::THR_W-1:0];
          default: ;
        endcase
      end else if (accept) begin
        if (is_large) begin
          active_gains <= large_gains;
        end
        if (is_outside) begin
          prev_error_1 <= error_sample;
          prev_error_2 <= prev_error_1;
          prev_error_3 <= prev_error_2;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/pdsteer_queue.sv
// pdsteer_queue: short fifo between the front and back parts
// depth from pdsteer_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdsteer_queue #(
  parameter int WIDTH = 48
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty,
  output logic                  full
);

  localparam int DEPTH = pdsteer_pkg::QUEUE_DEPTH;
  localparam int PW    = pdsteer_pkg::QPTR_W;
  localparam int CNTW  = pdsteer_pkg::QCNT_W;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             do_pop;

  assign not_empty = count != '0;
  assign full      = count == CNTW'(DEPTH);
  assign pop_data  = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (!push && do_pop) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/pdsteer_back.sv
// pdsteer_back: products, sum, clamp and divide by five, output register
// uses pdsteer_pkg; fed from pdsteer_queue
`timescale 1ns / 1ps
`default_nettype none

module pdsteer_back #(
  parameter int ERROR_WIDTH = 12,
  parameter int DRIVE_LIMIT = 200
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             op_valid,
  input  wire logic signed [ERROR_WIDTH-1:0]    op_error,
  input  wire logic signed [ERROR_WIDTH+2:0]    op_deriv,
  input  wire pdsteer_pkg::gains_t              op_gains,
  input  wire logic                             op_active,
  output logic                                  op_pop,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic [pdsteer_pkg::DRIVE_W-1:0]       drive,
  output logic                                  saturated
);

  localparam int EW  = ERROR_WIDTH;
  localparam int PW  = EW + 9;
  localparam int QW_ = EW + 12;
  localparam int NW  = EW + 13;
  localparam int LIM5_INT = 5 * (DRIVE_LIMIT + 1);
  localparam int MAGW = $clog2(LIM5_INT);
  localparam int K    = MAGW + 3;
  localparam int MW   = K - 2;
  localparam int RECIP_INT = (2 ** K + 4) / 5;
  localparam int DIVW = MAGW - 2;
  localparam int RW   = MAGW + pdsteer_pkg::DRIVE_W;

  localparam logic signed [NW-1:0] LIM5     = NW'(LIM5_INT);
  localparam logic signed [NW-1:0] LIM5_NEG = -LIM5;
  localparam logic [MW-1:0]        RECIP    = MW'(RECIP_INT);
  localparam logic [RW-1:0]        LIMP     = RW'(DRIVE_LIMIT);
  localparam logic [RW-1:0]        LIMN     = -LIMP;

  logic advance;

  // stage 1: products
  logic                 v1;
  logic                 act1;
  logic signed [PW-1:0] p1;
  logic signed [QW_-1:0] q1;
  logic signed [PW-1:0] p_mul;
  logic signed [QW_-1:0] q_mul;

  // stage 2: sum and range check
  logic                 v2;
  logic                 act2;
  logic                 sgn2;
  logic                 satp2;
  logic                 satn2;
  logic [MAGW-1:0]      mag2;
  logic signed [NW-1:0] num;
  logic signed [NW-1:0] num_abs;

  // stage 3: divide by five through reciprocal
  logic [MAGW+MW-1:0]   prod;
  logic [DIVW-1:0]      quot;
  logic [RW-1:0]        quot_x;
  logic [RW-1:0]        val;

  assign advance = !result_valid || !result_stall;
  assign op_pop  = advance;

  assign p_mul = $signed({1'b0, op_gains.kp}) * op_error;
  assign q_mul = $signed({1'b0, op_gains.kd}) * op_deriv;

  always_comb begin
    num     = (NW'(p1) <<< 2) + NW'(p1) + NW'(q1);
    num_abs = num[NW-1] ? -num : num;
    prod    = MAGW'(mag2) * (MAGW + MW)'(RECIP);
    quot    = prod[MAGW+MW-1:K];
    quot_x  = RW'(quot);
    if (!act2) begin
      val = '0;
    end else if (satp2) begin
      val = LIMP;
    end else if (satn2) begin
      val = LIMN;
    end else begin
      val = sgn2 ? -quot_x : quot_x;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      act1  <= op_active;
      p1    <= p_mul;
      q1    <= q_mul;
      act2  <= act1;
      sgn2  <= num[NW-1];
      satp2 <= num >= LIM5;
      satn2 <= num <= LIM5_NEG;
      mag2  <= num_abs[MAGW-1:0];
      drive     <= val[pdsteer_pkg::DRIVE_W-1:0];
      saturated <= act2 && (satp2 || satn2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v1           <= op_valid;
      v2           <= v1;
      result_valid <= v2;
    end
  end

endmodule

`default_nettype wire

### rtl/pd_steering_with_deadband.sv
// pd_steering_with_deadband: top level of the steering pd controller
// uses pdsteer_pkg, pdsteer_front, pdsteer_queue, pdsteer_back
//
//   channel   handshake                    payload
//   sample    sample_valid / sample_stall  error_sample
//   result    result_valid / result_stall  drive, saturated
//   config    cfg_write                    cfg_index, cfg_data
//
// one transaction per cycle in and out unless a stall holds it; a result's path from its sample is
// queue slot, product stage, sum stage, output register
// sample_stall rises only when the 4-entry queue is full behind a stalled result
// rst is synchronous; the queue and the back pipeline come out empty
`timescale 1ns / 1ps
`default_nettype none

module pd_steering_with_deadband #(
  parameter int ERROR_WIDTH = 12,
  parameter int DRIVE_LIMIT = 200
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [pdsteer_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pdsteer_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                sample_valid,
  output logic                                     sample_stall,
  input  wire logic signed [ERROR_WIDTH-1:0]       error_sample,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic signed [pdsteer_pkg::DRIVE_W-1:0]   drive,
  output logic                                     saturated
);

  localparam int EW = ERROR_WIDTH;
  localparam int DW = EW + 3;
  localparam int GW = 2 * pdsteer_pkg::GAIN_W;
  localparam int QW = 1 + GW + DW + EW;

  logic                 accept;
  logic signed [EW-1:0] f_error;
  logic signed [DW-1:0] f_deriv;
  pdsteer_pkg::gains_t  f_gains;
  logic                 f_active;

  logic [QW-1:0]        q_in;
  logic [QW-1:0]        q_out;
  logic                 q_not_empty;
  logic                 q_full;
  logic                 q_pop;

  logic [pdsteer_pkg::DRIVE_W-1:0] drive_bits;

  assign sample_stall = q_full;
  assign accept       = sample_valid && !sample_stall;
  assign q_in         = {f_active, f_gains, f_deriv, f_error};
  assign drive        = $signed(drive_bits);

  pdsteer_front #(
    .ERROR_WIDTH(ERROR_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .error_sample(error_sample),
    .op_error    (f_error),
    .op_deriv    (f_deriv),
    .op_gains    (f_gains),
    .op_active   (f_active)
  );

  pdsteer_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  pdsteer_back #(
    .ERROR_WIDTH(ERROR_WIDTH),
    .DRIVE_LIMIT(DRIVE_LIMIT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (q_not_empty),
    .op_error    ($signed(q_out[EW-1:0])),
    .op_deriv    ($signed(q_out[EW+DW-1:EW])),
    .op_gains    (pdsteer_pkg::gains_t'(q_out[EW+DW+GW-1:EW+DW])),
    .op_active   (q_out[QW-1]),
    .op_pop      (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .drive       (drive_bits),
    .saturated   (saturated)
  );

endmodule

`default_nettype wire

### rtl/pdsteer_checker.sv
// pdsteer_checker: port-level assertions for pd_steering_with_deadband
// bound to the top level; uses pdsteer_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdsteer_checker #(
  parameter int DRIVE_LIMIT = 200
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              sample_stall,
  input wire logic                              result_valid,
  input wire logic                              result_stall,
  input wire logic [pdsteer_pkg::DRIVE_W-1:0]   drive,
  input wire logic                              saturated
);

  localparam logic [31:0] LIMP = 32'(DRIVE_LIMIT);
  localparam logic [31:0] LIMN = -LIMP;

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |->
      drive == LIMP[pdsteer_pkg::DRIVE_W-1:0] || drive == LIMN[pdsteer_pkg::DRIVE_W-1:0])
    else $error("saturated result not at the drive limit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("block not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(drive) && $stable(saturated))
    else $error("stalled result changed");

  a_result_taken: assert property (@(posedge clk) disable iff (rst)
    $fell(result_valid) |-> $past(!result_stall))
    else $error("result dropped before transaction");

endmodule

bind pd_steering_with_deadband pdsteer_checker #(
  .DRIVE_LIMIT(DRIVE_LIMIT)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_stall(sample_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .drive       (drive),
  .saturated   (saturated)
);

`default_nettype wire

### bench/testbench.sv
// testbench: self-checking bench for pd_steering_with_deadband, sample and result
// channels under random idling, predicted drive checked per transaction
// depends on pdsteer_pkg and the pd_steering_with_deadband rtl
`timescale 1ns / 1ps

module testbench;

  localparam int CFG_IDX_W  = pdsteer_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = pdsteer_pkg::CFG_DATA_W;
  localparam int GAIN_W     = pdsteer_pkg::GAIN_W;
  localparam int THR_W      = pdsteer_pkg::THR_W;
  localparam int DRIVE_W    = pdsteer_pkg::DRIVE_W;

  localparam int ERR_W   = 12;
  localparam int LIMIT   = 200;
  localparam int LATENCY = 4;

  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_HI = 3'd7;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      saturated;
  } steer_out_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;
  logic                         sample_valid = 1'b0;
  logic                         sample_stall;
  logic signed [ERR_W-1:0]      error_sample = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic signed [DRIVE_W-1:0]    drive;
  logic                         saturated;

  pd_steering_with_deadband #(
    .ERROR_WIDTH(ERR_W),
    .DRIVE_LIMIT(LIMIT)
  ) DUT (.*);

  always #5 clk = ~clk;

  // controller state mirrored by the bench
  logic [GAIN_W-1:0]       large_kp = '0, large_kd = '0;
  logic [GAIN_W-1:0]       preset_kp = '0, preset_kd = '0;
  logic [GAIN_W-1:0]       act_kp = '0, act_kd = '0;
  logic [THR_W-1:0]        large_thr = pdsteer_pkg::LARGE_THR_RESET;
  logic [THR_W-1:0]        dead_band = pdsteer_pkg::DEADBAND_RESET;
  logic signed [ERR_W-1:0] hist1 = '0, hist2 = '0, hist3 = '0;

  logic signed [ERR_W-1:0] pending_q[$];
  steer_out_t              drive_expect_q[$];

  int  items_queued = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  clamped_count = 0;
  int  zero_drive_count = 0;
  int  setting_count = 0;
  bit  quiet = 1'b0;
  bit  took_sample = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic void set_register(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] val);
    case (idx)
      pdsteer_pkg::REG_LARGE_KP:  large_kp = val[GAIN_W-1:0];
      pdsteer_pkg::REG_LARGE_KD:  large_kd = val[GAIN_W-1:0];
      pdsteer_pkg::REG_INIT_KP: begin
        preset_kp = val[GAIN_W-1:0];
        act_kp = preset_kp;
      end
      pdsteer_pkg::REG_INIT_KD: begin
        preset_kd = val[GAIN_W-1:0];
        act_kd = preset_kd;
      end
      pdsteer_pkg::REG_LARGE_THR: large_thr = val[THR_W-1:0];
      pdsteer_pkg::REG_DEADBAND:  dead_band = val[THR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic steer_out_t steer_predict(logic signed [ERR_W-1:0] e0);
    longint     e, mag, slope, num, cmd;
    steer_out_t r;
    e = e0;
    mag = (e < 0) ? -e : e;
    cmd = 0;
    r.saturated = 1'b0;
    if (mag > longint'(large_thr)) begin
      act_kp = large_kp;
      act_kd = large_kd;
    end
    if (mag > longint'(dead_band)) begin
      slope = 3 * (e - longint'(hist1)) + (longint'(hist1) - longint'(hist2))
              + (longint'(hist2) - longint'(hist3));
      num = 5 * longint'(act_kp) * e + longint'(act_kd) * slope;
      cmd = num / 5;
      hist3 = hist2;
      hist2 = hist1;
      hist1 = e0;
      if (cmd > LIMIT) begin
        cmd = LIMIT;
        r.saturated = 1'b1;
      end else if (cmd < -LIMIT) begin
        cmd = -LIMIT;
        r.saturated = 1'b1;
      end
    end
    if (r.saturated) clamped_count++;
    if (cmd == 0) zero_drive_count++;
    r.drive = cmd[DRIVE_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result check first, then prediction of the sample taken at this edge
  always @(posedge clk) begin
    steer_out_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (drive_expect_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: drive %0d sat %0b",
                                  drive, saturated));
      end else begin
        want = drive_expect_q.pop_front();
        if (drive !== want.drive)
          report_mismatch($sformatf("drive %0d, expected %0d", drive, want.drive));
        if (saturated !== want.saturated)
          report_mismatch($sformatf("saturated %0b, expected %0b",
                                    saturated, want.saturated));
      end
    end
    if (!rst && sample_valid && !sample_stall)
      drive_expect_q.push_back(steer_predict(error_sample));
    took_sample <= !rst && sample_valid && !sample_stall;
  end

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || took_sample) begin
      if (send_gap > 0) begin
        sample_valid <= 1'b0;
        send_gap--;
      end else if (pending_q.size() > 0) begin
        error_sample <= pending_q.pop_front();
        sample_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    set_register(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // gain word with random junk above the 8 register bits
  function automatic logic [CFG_DATA_W-1:0] gain_word(int g);
    return CFG_DATA_W'(g + ($urandom_range(0, 7) << GAIN_W));
  endfunction

  task automatic set_all(int lkp, int lkd, int ikp, int ikd, int thr, int db);
    write_reg(pdsteer_pkg::REG_LARGE_KP, gain_word(lkp));
    write_reg(pdsteer_pkg::REG_LARGE_KD, gain_word(lkd));
    write_reg(pdsteer_pkg::REG_INIT_KP, gain_word(ikp));
    write_reg(pdsteer_pkg::REG_INIT_KD, gain_word(ikd));
    write_reg(pdsteer_pkg::REG_LARGE_THR, CFG_DATA_W'(thr));
    write_reg(pdsteer_pkg::REG_DEADBAND, CFG_DATA_W'(db));
    setting_count++;
  endtask

  task automatic queue_sample(int e);
    pending_q.push_back(e[ERR_W-1:0]);
    items_queued++;
  endtask

  task automatic drain();
    while (results_seen != items_queued) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  function automatic int gen_error(int last);
    int r, v, lvl;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      v = int'($urandom_range(0, 400)) - 200;
    end else if (r < 45) begin
      v = int'($urandom_range(0, 4095)) - 2048;
    end else if (r < 60) begin
      lvl = $urandom_range(0, 1) ? int'(dead_band) : int'(large_thr);
      v = lvl + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1)) v = -v;
    end else begin
      v = last + int'($urandom_range(0, 40)) - 20;
    end
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v;
  endfunction

  task automatic random_phase(int n);
    int last;
    last = 0;
    quiet = ($urandom_range(0, 3) == 0);
    @(posedge clk);
    repeat (n) begin
      last = gen_error(last);
      queue_sample(last);
    end
    drain();
  endtask

  function automatic int rand_gain();
    return $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 255);
  endfunction

  function automatic int drain_left();
    return drive_expect_q.size();
  endfunction

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset settings: all gains zero
    @(posedge clk);
    queue_sample(0);
    queue_sample(3);
    queue_sample(-3);
    queue_sample(4);
    queue_sample(2047);
    queue_sample(-2048);
    drain();

    // unity proportional gain, no deadband: limit edges
    set_all(1, 0, 1, 0, 2047, 0);
    @(posedge clk);
    queue_sample(200);
    queue_sample(-200);
    queue_sample(201);
    queue_sample(-201);
    queue_sample(199);
    queue_sample(0);
    queue_sample(1);
    queue_sample(-1);
    queue_sample(2047);
    queue_sample(-2048);
    drain();

    // unmapped indexes must be ignored
    write_reg(UNMAPPED_REG_LO, CFG_DATA_W'($urandom_range(0, 2047)));
    write_reg(UNMAPPED_REG_HI, CFG_DATA_W'($urandom_range(0, 2047)));

    // deadband and large-error reload around the default thresholds
    set_all(3, 40, 2, 5, 70, 3);
    @(posedge clk);
    queue_sample(4);
    queue_sample(10);
    queue_sample(-10);
    queue_sample(69);
    queue_sample(70);
    queue_sample(71);
    queue_sample(20);
    queue_sample(-3);
    queue_sample(-4);
    queue_sample(5);
    drain();

    set_all(0, 0, 0, 0, 0, 0);
    random_phase(85);
    set_all(255, 255, 255, 255, 2047, 2047);
    random_phase(85);
    set_all(255, 255, 0, 0, 0, 0);
    random_phase(85);
    repeat (5) begin
      set_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
              $urandom_range(0, 1) ? $urandom_range(0, 150) : $urandom_range(0, 2047),
              $urandom_range(0, 3) != 0 ? $urandom_range(0, 20) : $urandom_range(0, 2047));
      random_phase(85);
    end

    if (drain_left() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", drain_left()));
    $display("covered %0d samples over %0d register settings", items_queued, setting_count);
    $display("%0d results clamped, %0d with zero drive", clamped_count, zero_drive_count);
    if (mismatch_count == 0) begin
      $display("pd_steering_with_deadband test passed");
    end else begin
      $display("pd_steering_with_deadband test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("pd_steering_with_deadband test failed");
    $finish;
  end

endmodule

### filelist.f
rtl/pdsteer_pkg.sv
rtl/pdsteer_front.sv
rtl/pdsteer_queue.sv
rtl/pdsteer_back.sv
rtl/pd_steering_with_deadband.sv
rtl/pdsteer_checker.sv
bench/testbench.sv
